// ----- rtl/core/complex_channel_window_averager_unit_macros.svh -----
// Assertion macros used by the checker of the window averager.
`ifndef COMPLEX_CHANNEL_WINDOW_AVERAGER_UNIT_MACROS_SVH
`define COMPLEX_CHANNEL_WINDOW_AVERAGER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CCWA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window averager check failed");

// Next-cycle implication, disabled while reset is low.
`define CCWA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window averager check failed");

`endif

// ----- rtl/core/ccwa_pkg.sv -----
// Shared widths, register indexes, command types and the averaging divide.
package ccwa_pkg;

    localparam int DATA_W = 16;
    localparam int CHAN_W = 14;
    localparam int ACC_W  = 27;
    localparam int CNT_W  = 11;
    localparam int LG_W   = 4;
    localparam int IDX_W  = 2;

    localparam logic [LG_W-1:0]   LG_MAX   = 4'd10;
    localparam logic [CHAN_W-1:0] END_INIT = 14'd16383;

    // Command queue geometry.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_START = 2'd0;
    localparam logic [IDX_W-1:0] REG_END   = 2'd1;
    localparam logic [IDX_W-1:0] REG_AVG   = 2'd2;

    // Live configuration as seen by the front and back parts.
    typedef struct packed {
        logic [CHAN_W-1:0] start_chan;
        logic [CHAN_W-1:0] end_chan;
        logic [LG_W-1:0]   lg;
    } t_cfg;

    // One classified channel handed from the front to the back.
    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     clr;
        logic                     keep;
        logic                     is_end;
    } t_cmd;

    // Divide a group sum by 2^lg, truncating toward zero.
    function automatic logic [DATA_W-1:0] avg_div(input logic signed [ACC_W-1:0] sum,
                                                  input logic [LG_W-1:0] lg);
        logic [ACC_W-1:0]        bias;
        logic signed [ACC_W-1:0] adj;
        logic signed [ACC_W-1:0] quo;
        bias = sum[ACC_W-1] ? ((ACC_W'(1) << lg) - ACC_W'(1)) : '0;
        adj  = sum + $signed(bias);
        quo  = adj >>> lg;
        return quo[DATA_W-1:0];
    endfunction

endpackage

// ----- rtl/core/ccwa_front.sv -----
// Front part: accepts channel beats, numbers them and classifies each one.
module ccwa_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [31:0]            i_data,
    input  logic                   i_start,
    input  ccwa_pkg::t_cfg         i_cfg,
    input  logic                   i_q_full,
    output logic                   o_push,
    output ccwa_pkg::t_cmd         o_cmd
);

    logic [ccwa_pkg::CHAN_W-1:0] r_chan_cnt;
    logic [ccwa_pkg::CHAN_W-1:0] n_chan_cnt;
    logic [ccwa_pkg::CHAN_W-1:0] idx;
    logic                        accept;
    logic                        keep;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    // A spectrum start renumbers this beat as channel zero.
    always_comb begin
        idx        = i_start ? '0 : r_chan_cnt;
        n_chan_cnt = idx + ccwa_pkg::CHAN_W'(1);
        keep       = (idx >= i_cfg.start_chan) && (idx <= i_cfg.end_chan);
    end

    // Only beats that touch the group state go to the back part.
    always_comb begin
        o_push        = accept && (keep || i_start);
        o_cmd.re      = $signed(i_data[15:0]);
        o_cmd.im      = $signed(i_data[31:16]);
        o_cmd.clr     = i_start;
        o_cmd.keep    = keep;
        o_cmd.is_end  = (idx == i_cfg.end_chan);
    end

    // Channel counter wraps at the channel space size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= '0;
        end else if (accept) begin
            r_chan_cnt <= n_chan_cnt;
        end
    end

endmodule

// ----- rtl/core/ccwa_queue.sv -----
// Short command queue between the front and back parts.
module ccwa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ccwa_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output ccwa_pkg::t_cmd  o_cmd
);

    ccwa_pkg::t_cmd           r_slot [ccwa_pkg::QDEPTH];
    logic [ccwa_pkg::QAW-1:0] r_wr_ptr;
    logic [ccwa_pkg::QAW-1:0] r_rd_ptr;
    logic [ccwa_pkg::QCW-1:0] r_count;
    logic                     do_push;
    logic                     do_pop;

    assign o_full  = (r_count == ccwa_pkg::QCW'(ccwa_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + ccwa_pkg::QAW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + ccwa_pkg::QAW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + ccwa_pkg::QCW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - ccwa_pkg::QCW'(1);
            end
        end
    end

endmodule

// ----- rtl/core/ccwa_back.sv -----
// Back part: accumulates groups, divides finished sums and holds the output beat.
module ccwa_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  ccwa_pkg::t_cmd              i_cmd,
    output logic                        o_pop,
    input  logic [ccwa_pkg::LG_W-1:0]   i_lg,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [31:0]                 o_data,
    output logic                        o_last
);

    logic signed [ccwa_pkg::ACC_W-1:0] r_acc_re;
    logic signed [ccwa_pkg::ACC_W-1:0] r_acc_im;
    logic [ccwa_pkg::CNT_W-1:0]        r_grp_cnt;

    logic                              r_s1_valid;
    logic signed [ccwa_pkg::ACC_W-1:0] r_s1_re;
    logic signed [ccwa_pkg::ACC_W-1:0] r_s1_im;
    logic                              r_s1_last;

    logic                              r_out_valid;
    logic [ccwa_pkg::DATA_W-1:0]       r_out_re;
    logic [ccwa_pkg::DATA_W-1:0]       r_out_im;
    logic                              r_out_last;

    logic signed [ccwa_pkg::ACC_W-1:0] base_re;
    logic signed [ccwa_pkg::ACC_W-1:0] base_im;
    logic [ccwa_pkg::CNT_W-1:0]        base_cnt;
    logic signed [ccwa_pkg::ACC_W-1:0] sum_re;
    logic signed [ccwa_pkg::ACC_W-1:0] sum_im;
    logic [ccwa_pkg::CNT_W-1:0]        cnt_inc;
    logic [ccwa_pkg::CNT_W-1:0]        grp_size;
    logic                              complete;
    logic                              out_free;
    logic                              s1_free;

    // Accumulate the head command on top of the open group.
    always_comb begin
        base_re  = i_cmd.clr ? '0 : r_acc_re;
        base_im  = i_cmd.clr ? '0 : r_acc_im;
        base_cnt = i_cmd.clr ? '0 : r_grp_cnt;
        sum_re   = base_re + {{(ccwa_pkg::ACC_W-ccwa_pkg::DATA_W){i_cmd.re[15]}}, i_cmd.re};
        sum_im   = base_im + {{(ccwa_pkg::ACC_W-ccwa_pkg::DATA_W){i_cmd.im[15]}}, i_cmd.im};
        cnt_inc  = base_cnt + ccwa_pkg::CNT_W'(1);
        grp_size = ccwa_pkg::CNT_W'(1) << i_lg;
        complete = i_cmd.keep && (cnt_inc >= grp_size);
    end

    // A finished group may only leave when the sum stage can take it.
    assign out_free = !r_out_valid || i_ready;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_pop    = i_q_valid && (!complete || s1_free);

    // Open group state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re  <= '0;
            r_acc_im  <= '0;
            r_grp_cnt <= '0;
        end else if (o_pop) begin
            if (i_cmd.keep && !complete && !i_cmd.is_end) begin
                r_acc_re  <= sum_re;
                r_acc_im  <= sum_im;
                r_grp_cnt <= cnt_inc;
            end else if (i_cmd.keep || i_cmd.clr) begin
                r_acc_re  <= '0;
                r_acc_im  <= '0;
                r_grp_cnt <= '0;
            end
        end
    end

    // Sum stage holds a finished group before the divide.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_pop && complete) begin
            r_s1_valid <= 1'b1;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && complete) begin
            r_s1_re   <= sum_re;
            r_s1_im   <= sum_im;
            r_s1_last <= i_cmd.is_end;
        end
    end

    // Output register takes the divided bin.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_re   <= ccwa_pkg::avg_div(r_s1_re, i_lg);
            r_out_im   <= ccwa_pkg::avg_div(r_s1_im, i_lg);
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = {r_out_im, r_out_re};
    assign o_last  = r_out_last;

endmodule

// ----- rtl/core/complex_channel_window_averager_unit.sv -----
// Complex channel window averager: top level with configuration registers.
//
// Input stream: one complex channel per beat, tdata holds the real part in
// bits 15:0 and the imaginary part in bits 31:16; tuser bit 0 marks channel
// zero of a new spectrum and discards any partial group. Channels from
// start_channel to end_channel are kept and gathered in groups of
// 2^average_log2 (capped at 1024). Each group leaves as one output beat with
// both sums divided by the group size, truncated toward zero; tlast marks the
// bin that ends at end_channel. A partial group left at end_channel is dropped.
// Throughput is one channel per cycle while the receiver keeps up, set by the
// accumulate in the back part. A bin's last channel passes through the command
// queue, the sum stage and the output register before the bin is presented.
// When the receiver stalls, the output register, a sum stage and a four-entry
// command queue fill before s_axis_tready drops. Reset clears the channel
// count, the open group and all valid flags, and sets the registers to start
// 0, end 16383, average_log2 0. The configuration channel is always ready;
// write it only while the block is idle.
module complex_channel_window_averager_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // real_part, imag_part
    input  logic [0:0]                      s_axis_tuser,  // spectrum_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // avg_real, avg_imag
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ccwa_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [ccwa_pkg::CHAN_W-1:0]     i_cfg_data
);

    logic [ccwa_pkg::CHAN_W-1:0] r_start_chan;
    logic [ccwa_pkg::CHAN_W-1:0] r_end_chan;
    logic [ccwa_pkg::LG_W-1:0]   r_avg_log2;
    ccwa_pkg::t_cfg              cfg;
    logic                        q_full;
    logic                        q_valid;
    logic                        push;
    logic                        pop;
    ccwa_pkg::t_cmd              front_cmd;
    ccwa_pkg::t_cmd              head_cmd;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_chan <= '0;
            r_end_chan   <= ccwa_pkg::END_INIT;
            r_avg_log2   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ccwa_pkg::REG_START: r_start_chan <= i_cfg_data;
                ccwa_pkg::REG_END:   r_end_chan   <= i_cfg_data;
                ccwa_pkg::REG_AVG:   r_avg_log2   <= i_cfg_data[ccwa_pkg::LG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Group size exponent saturates at the largest group.
    always_comb begin
        cfg.start_chan = r_start_chan;
        cfg.end_chan   = r_end_chan;
        cfg.lg         = (r_avg_log2 > ccwa_pkg::LG_MAX) ? ccwa_pkg::LG_MAX : r_avg_log2;
    end

    ccwa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_start  (s_axis_tuser[0]),
        .i_cfg    (cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    ccwa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (head_cmd)
    );

    ccwa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .i_lg      (cfg.lg),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule

// ----- rtl/core/ccwa_checker.sv -----
// Port-level checker for the window averager and its bind to the top level.
`include "complex_channel_window_averager_unit_macros.svh"

module ccwa_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [31:0]                 m_axis_tdata,
    input  logic                        m_axis_tlast
);

    logic [15:0] r_credit;
    logic        r_sat;
    logic        in_beat;
    logic        out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    // Count input beats not yet matched by output beats; stop checking on overflow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
            r_sat    <= 1'b0;
        end else begin
            if (in_beat && (r_credit == 16'hFFFF)) begin
                r_sat <= 1'b1;
            end
            r_credit <= r_credit + 16'(in_beat) - 16'(out_beat);
        end
    end

    // A stalled output beat holds its payload.
    `CCWA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // Every output bin is backed by at least one earlier input channel.
    `CCWA_ASSERT_IMP(a_out_backed, i_clk, i_rst_n, out_beat && !r_sat, r_credit != 16'd0)

    // Input backpressure only follows a stalled output.
    `CCWA_ASSERT_IMP(a_bp_cause, i_clk, i_rst_n, !s_axis_tready, $past(m_axis_tvalid && !m_axis_tready))

endmodule

bind complex_channel_window_averager_unit ccwa_checker u_ccwa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
